[sv/clfp_pkg.sv]
// ----------------------------------------------------------------------------
// clfp_pkg
// Shared types, constants and helpers for the cursor list free pool.
// ----------------------------------------------------------------------------
package clfp_pkg;

  // Pool geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LINK_W  = IDX_W + 1;
  localparam int STEP_W  = $clog2(ENTRIES + 1);
  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 4;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [STEP_W-1:0] step_t;

  // Null link: all ones
  localparam link_t LINK_NIL = '1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_START,
    S_DEL_CMP,
    S_DEL_FREE,
    S_REPLY
  } state_t;

  // Pool memory requests from the sequencer
  typedef struct packed {
    logic               val_we;
    logic               next_we;
    idx_t               waddr;
    idx_t               raddr;
    logic [VALUE_W-1:0] val_wdata;
    link_t              next_wdata;
  } mem_req_t;

  // A link names a slot only when it is below the pool size
  function automatic logic link_ok(link_t l);
    return l < LINK_W'(ENTRIES);
  endfunction

  // Any link that is not a slot becomes null
  function automatic link_t link_clean(link_t l);
    return link_ok(l) ? l : LINK_NIL;
  endfunction

  function automatic idx_t link_idx(link_t l);
    return l[IDX_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] to_slot(idx_t i);
    return SLOT_W'(i);
  endfunction

endpackage

[sv/cursor_list_free_pool.sv]
// ----------------------------------------------------------------------------
// cursor_list_free_pool
// Fixed pool holding one singly linked list and a free chain, threaded
// through a next-index memory. Insert at front, delete first match.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | op, value
//  rsp     | out       | rsp_valid/rsp_stall  | status, slot
//
//  Insert: link fetch, write, reply; a full pool skips the write.
//  Delete: start at the head, compare entries with one link read per cycle,
//  then unlink and free on a hit; a miss ends after at most ENTRIES entries.
//  After reset a clearing pass over all ENTRIES slots loads the free chain;
//  req_stall is high during it. A stalled result in the output register blocks
//  only the next reply, not the transfer of the next request.
// ----------------------------------------------------------------------------
module cursor_list_free_pool (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  clfp_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output clfp_pkg::rsp_t rsp
);
  import clfp_pkg::*;

  mem_req_t           mem;
  logic [VALUE_W-1:0] val_rd;
  link_t              next_rd;

  clfp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .mem       (mem),
    .val_rd    (val_rd),
    .next_rd   (next_rd)
  );

  // Stored values
  clfp_ram #(.WIDTH(VALUE_W), .DEPTH(ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (mem.val_we),
    .waddr (mem.waddr),
    .wdata (mem.val_wdata),
    .raddr (mem.raddr),
    .rdata (val_rd)
  );

  // Next-index links
  clfp_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_next_ram (
    .clk   (clk),
    .we    (mem.next_we),
    .waddr (mem.waddr),
    .wdata (mem.next_wdata),
    .raddr (mem.raddr),
    .rdata (next_rd)
  );

endmodule

[sv/clfp_ram.sv]
// ----------------------------------------------------------------------------
// clfp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module clfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/clfp_seq.sv]
// ----------------------------------------------------------------------------
// clfp_seq
// Sequencer for insert and delete: drives the pool memories, walks the list
// one link per cycle through the shared value compare, holds the result.
// ----------------------------------------------------------------------------
module clfp_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  clfp_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output clfp_pkg::rsp_t                  rsp,
  output clfp_pkg::mem_req_t              mem,
  input  logic [clfp_pkg::VALUE_W-1:0]    val_rd,
  input  clfp_pkg::link_t                 next_rd
);
  import clfp_pkg::*;

  state_t             state, state_next;
  logic [VALUE_W-1:0] val;
  link_t              cur, cur_next;
  link_t              prev, prev_next;
  step_t              steps, steps_next;
  link_t              list_head, list_head_next;
  link_t              free_head, free_head_next;
  idx_t               init_cnt;
  rsp_t               result, result_next;
  rsp_t               rsp_next;
  logic               rsp_valid_next;
  logic               accept;
  logic               hit;
  logic               walk_more;
  logic               init_last;
  logic               reply_go;

  assign accept    = req_valid && !req_stall;
  assign hit       = (val_rd == val);
  assign walk_more = link_ok(next_rd) && ((steps + STEP_W'(1)) < STEP_W'(ENTRIES));
  assign init_last = (init_cnt == IDX_W'(ENTRIES - 1));
  assign reply_go  = !rsp_valid || !rsp_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT:      if (init_last) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) state_next = (req.op == OP_INSERT) ? S_INS_RD : S_DEL_START;
      end
      S_INS_RD:    state_next = link_ok(free_head) ? S_INS_WR : S_REPLY;
      S_INS_WR:    state_next = S_REPLY;
      S_DEL_START: state_next = link_ok(list_head) ? S_DEL_CMP : S_REPLY;
      S_DEL_CMP: begin
        if (hit)             state_next = S_DEL_FREE;
        else if (!walk_more) state_next = S_REPLY;
      end
      S_DEL_FREE:  state_next = S_REPLY;
      S_REPLY:     if (reply_go) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Memory requests and datapath next values
  always_comb begin
    req_stall      = (state != S_IDLE);
    mem            = '0;
    mem.raddr      = link_idx(cur);
    mem.val_wdata  = val;
    cur_next       = cur;
    prev_next      = prev;
    steps_next     = steps;
    list_head_next = list_head;
    free_head_next = free_head;
    result_next    = result;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    case (state)
      // Clearing pass: slot i links to i-1, slot 0 is null
      S_INIT: begin
        mem.next_we    = 1'b1;
        mem.waddr      = init_cnt;
        mem.next_wdata = (init_cnt == '0) ? LINK_NIL : (LINK_W'(init_cnt) - LINK_W'(1));
      end
      S_IDLE: ;
      // Fetch the link of the first free slot
      S_INS_RD: begin
        mem.raddr = link_idx(free_head);
        if (!link_ok(free_head)) begin
          result_next = '{status: ST_FULL, slot: '0};
        end
      end
      // Store value, link slot at the list front, advance free chain
      S_INS_WR: begin
        mem.val_we     = 1'b1;
        mem.next_we    = 1'b1;
        mem.waddr      = link_idx(free_head);
        mem.next_wdata = link_clean(list_head);
        free_head_next = link_clean(next_rd);
        list_head_next = free_head;
        result_next    = '{status: ST_DONE, slot: to_slot(link_idx(free_head))};
      end
      // Start the walk at the head
      S_DEL_START: begin
        mem.raddr  = link_idx(list_head);
        cur_next   = list_head;
        prev_next  = LINK_NIL;
        steps_next = '0;
        if (!link_ok(list_head)) begin
          result_next = '{status: ST_NOT_FOUND, slot: '0};
        end
      end
      // One compare per cycle; on a match unlink, else follow the link
      S_DEL_CMP: begin
        if (hit) begin
          if (link_ok(prev)) begin
            mem.next_we    = 1'b1;
            mem.waddr      = link_idx(prev);
            mem.next_wdata = link_clean(next_rd);
          end else begin
            list_head_next = link_clean(next_rd);
          end
        end else begin
          mem.raddr  = link_idx(next_rd);
          prev_next  = cur;
          cur_next   = next_rd;
          steps_next = steps + STEP_W'(1);
          if (!walk_more) begin
            result_next = '{status: ST_NOT_FOUND, slot: '0};
          end
        end
      end
      // Push the freed slot onto the free chain
      S_DEL_FREE: begin
        mem.next_we    = 1'b1;
        mem.waddr      = link_idx(cur);
        mem.next_wdata = link_clean(free_head);
        free_head_next = cur;
        result_next    = '{status: ST_DONE, slot: to_slot(link_idx(cur))};
      end
      // Hand the result to the output register once it is free
      S_REPLY: begin
        if (reply_go) begin
          rsp_valid_next = 1'b1;
          rsp_next       = result;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_cnt  <= '0;
      list_head <= LINK_NIL;
      free_head <= LINK_W'(ENTRIES - 1);
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      list_head <= list_head_next;
      free_head <= free_head_next;
      rsp_valid <= rsp_valid_next;
      if (state == S_INIT && !init_last) begin
        init_cnt <= init_cnt + IDX_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      val <= req.value;
    end
    cur    <= cur_next;
    prev   <= prev_next;
    steps  <= steps_next;
    result <= result_next;
    rsp    <= rsp_next;
  end

endmodule

[sv/clfp_checker.sv]
// ----------------------------------------------------------------------------
// clfp_checker
// Port-level checks for the cursor list free pool, bound to the top level.
// ----------------------------------------------------------------------------
module clfp_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input clfp_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input clfp_pkg::rsp_t rsp
);
  import clfp_pkg::*;

  // Stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // Slot is zero unless the operation completed
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_DONE) |-> (rsp.slot == '0))
    else $error("slot nonzero on failed operation");

  // One item at a time: busy right after a request transfer
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while busy");

  // A new result only comes out of a busy period
  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response without work");

endmodule

bind cursor_list_free_pool clfp_checker u_clfp_checker (.*);

[tb/sv/cursor_list_free_pool_test.sv]
// ----------------------------------------------------------------------------
// cursor_list_free_pool_test
// Self-checking bench for the cursor list free pool. A queue-fed driver sends
// insert and delete requests; a shadow copy of the pool (value store, link
// store, list and free heads) predicts each reply, and a monitor compares
// every reply transfer against the oldest prediction. Both sides idle and
// stall at random, with quiet stretches and two full drains in between.
// ----------------------------------------------------------------------------
module cursor_list_free_pool_test;
  timeunit 1ns;
  timeprecision 1ps;

  import clfp_pkg::*;

  typedef struct {
    req_t        req;
    int unsigned gap;    // idle cycles before this request is offered
    bit          drain;  // hold until every owed reply is back
  } feed_item_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  cursor_list_free_pool u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  // Shadow pool
  logic signed [VALUE_W-1:0] pool_value [ENTRIES];
  link_t                     pool_link  [ENTRIES];
  link_t                     live_head;
  link_t                     spare_head;

  // Request feed and reply bookkeeping
  feed_item_t                req_backlog [$];
  feed_item_t                next_feed;
  bit                        have_next = 1'b0;
  int unsigned               gap_left  = 0;
  rsp_t                      owed_replies [$];
  rsp_t                      staged_reply = '0;
  logic                      staged_live  = 1'b0;
  int unsigned               req_taken    = 0;
  int unsigned               replies_seen = 0;
  int unsigned               stall_left   = 0;
  int unsigned               mismatch_count = 0;

  // Values the generator believes are on the list (multiset)
  logic signed [VALUE_W-1:0] listed_values [$];

  task automatic note_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Apply one request to the shadow pool and return the reply it must give
  function automatic rsp_t predict_pool_reply(req_t r);
    rsp_t  reply;
    link_t prev;
    link_t cur;
    link_t nxt;
    int    hops;
    bit    hit;
    reply.status = ST_DONE;
    reply.slot   = '0;
    if (r.op == OP_INSERT) begin
      if (int'(spare_head) >= ENTRIES) begin
        reply.status = ST_FULL;
      end else begin
        cur = spare_head;
        spare_head = pool_link[cur[IDX_W-1:0]];
        pool_value[cur[IDX_W-1:0]] = r.value;
        pool_link[cur[IDX_W-1:0]]  = live_head;
        live_head  = cur;
        reply.slot = SLOT_W'(cur[IDX_W-1:0]);
      end
    end else begin
      prev = LINK_NIL;
      cur  = live_head;
      hops = 0;
      hit  = 1'b0;
      // walk from the head; first match nearest the head wins
      while (!hit && int'(cur) < ENTRIES && hops < ENTRIES) begin
        if (pool_value[cur[IDX_W-1:0]] == r.value) begin
          hit = 1'b1;
          nxt = pool_link[cur[IDX_W-1:0]];
          if (int'(prev) < ENTRIES) begin
            pool_link[prev[IDX_W-1:0]] = nxt;
          end else begin
            live_head = nxt;
          end
          pool_link[cur[IDX_W-1:0]] = spare_head;
          spare_head = cur;
          reply.slot = SLOT_W'(cur[IDX_W-1:0]);
        end else begin
          prev = cur;
          cur  = pool_link[cur[IDX_W-1:0]];
          hops++;
        end
      end
      if (!hit) reply.status = ST_NOT_FOUND;
    end
    return reply;
  endfunction

  // Mix of a few small values (for duplicates), extremes and full-range noise
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 7);
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_op(op_t op, logic signed [VALUE_W-1:0] v, bit calm, bit drain);
    feed_item_t f;
    int         k;
    f.req.op    = op;
    f.req.value = v;
    f.gap       = calm ? 0 : $urandom_range(0, 13);
    f.drain     = drain;
    req_backlog.push_back(f);
    // keep the generator's view of the list contents current
    if (op == OP_INSERT) begin
      if (listed_values.size() < ENTRIES) listed_values.push_back(v);
    end else begin
      for (k = 0; k < listed_values.size(); k++) begin
        if (listed_values[k] == v) begin
          listed_values.delete(k);
          break;
        end
      end
    end
  endtask

  // Request driver: predicts at each transfer, hands the reply over next edge
  always @(posedge clk) begin : drive_req
    logic took;
    if (rst) begin
      req_valid   <= 1'b0;
      req         <= '0;
      staged_live <= 1'b0;
      req_taken   <= 0;
      have_next   = 1'b0;
      gap_left    = 0;
      live_head   = LINK_NIL;
      spare_head  = link_t'(ENTRIES - 1);
      for (int i = 0; i < ENTRIES; i++) begin
        pool_value[i] = '0;
        pool_link[i]  = (i == 0) ? LINK_NIL : link_t'(i - 1);
      end
    end else begin
      took = req_valid && !req_stall;
      staged_live <= took;
      if (took) begin
        staged_reply <= predict_pool_reply(req);
        req_taken    <= req_taken + 1;
      end
      // channel free: offer the next request once its gap has run out and, for a drain item, every owed reply is back
      if (!req_valid || took) begin
        if (!have_next && req_backlog.size() > 0) begin
          next_feed = req_backlog.pop_front();
          gap_left  = next_feed.gap;
          have_next = 1'b1;
        end
        if (have_next && gap_left == 0 &&
            (!next_feed.drain || (!took && req_taken == replies_seen))) begin
          req_valid <= 1'b1;
          req       <= next_feed.req;
          have_next = 1'b0;
        end else begin
          req_valid <= 1'b0;
          if (have_next && gap_left > 0) gap_left--;
        end
      end
    end
  end

  // Reply monitor: checks each transfer against the oldest owed reply
  always @(posedge clk) begin : watch_rsp
    rsp_t want;
    if (rst) begin
      rsp_stall    <= 1'b0;
      replies_seen <= 0;
      stall_left   = 0;
    end else begin
      if (staged_live) owed_replies.push_back(staged_reply);
      if (rsp_valid && !rsp_stall) begin
        if (owed_replies.size() == 0) begin
          note_mismatch($sformatf("reply %0d arrived with nothing owed", replies_seen));
        end else begin
          want = owed_replies.pop_front();
          if (rsp.status !== want.status)
            note_mismatch($sformatf("reply %0d status %0d, want %0d",
                                    replies_seen, rsp.status, want.status));
          if (rsp.slot !== want.slot)
            note_mismatch($sformatf("reply %0d slot %0d, want %0d",
                                    replies_seen, rsp.slot, want.slot));
        end
        replies_seen <= replies_seen + 1;
        // two quiet windows with no back-pressure
        if ((replies_seen >= 300 && replies_seen < 400) ||
            (replies_seen >= 700 && replies_seen < 780)) begin
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 13);
        end
      end
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : run_main
    int                        n;
    int                        insert_pct;
    bit                        calm;
    logic signed [VALUE_W-1:0] v;

    // directed: empty list, extremes, duplicates, miss, full pool, delete when full
    queue_op(OP_DELETE, 32'sd7, 1'b0, 1'b0);
    queue_op(OP_INSERT, 32'sh8000_0000, 1'b0, 1'b0);
    queue_op(OP_INSERT, 32'sh7fff_ffff, 1'b0, 1'b0);
    queue_op(OP_INSERT, 32'sd0, 1'b0, 1'b0);
    queue_op(OP_INSERT, -32'sd1, 1'b0, 1'b0);
    queue_op(OP_DELETE, 32'sh7fff_ffff, 1'b0, 1'b0);
    queue_op(OP_INSERT, 32'sd5, 1'b0, 1'b0);
    queue_op(OP_INSERT, 32'sd5, 1'b0, 1'b0);
    queue_op(OP_DELETE, 32'sd5, 1'b0, 1'b0);
    queue_op(OP_DELETE, 32'sd1234, 1'b0, 1'b0);
    for (n = 0; n < 12; n++) queue_op(OP_INSERT, $urandom(), 1'b0, 1'b0);
    queue_op(OP_INSERT, 32'sd99, 1'b0, 1'b0);
    queue_op(OP_DELETE, 32'sh8000_0000, 1'b0, 1'b0);
    queue_op(OP_INSERT, 32'sd100, 1'b0, 1'b0);

    // random: alternating fill and drain phases, with deletes that mostly hit
    for (n = 0; n < 1000; n++) begin
      insert_pct = ((n / 40) % 2 == 0) ? 75 : 30;
      calm       = ((n / 100) % 5 == 2);
      if ($urandom_range(0, 99) < insert_pct) begin
        queue_op(OP_INSERT, pick_value(), calm, (n == 0 || n == 500));
      end else begin
        if (listed_values.size() > 0 && $urandom_range(0, 99) < 80)
          v = listed_values[$urandom_range(0, listed_values.size() - 1)];
        else
          v = pick_value();
        queue_op(OP_DELETE, v, calm, (n == 0 || n == 500));
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (req_backlog.size() != 0 || have_next || req_valid);
    do @(negedge clk); while (req_taken != replies_seen);
    repeat (30) @(posedge clk);
    if (owed_replies.size() != 0)
      note_mismatch($sformatf("%0d replies never arrived", owed_replies.size()));

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin : run_limit
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
sv/clfp_pkg.sv
sv/clfp_ram.sv
sv/clfp_seq.sv
sv/cursor_list_free_pool.sv
sv/clfp_checker.sv
tb/sv/cursor_list_free_pool_test.sv
